FILE: rtl/sstr_pkg.sv
// ============================================================================
// sstr_pkg
// Shared types and codes for the slot size table register core.
// ============================================================================
package sstr_pkg;

    // Input item as seen on the push side.
    typedef struct packed {
        logic        cmd;
        logic [15:0] address;
        logic [16:0] num_bytes;
    } in_item_t;

    // Result item as seen on the pop side.
    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  size_log;
        logic [15:0] object_base;
    } out_item_t;

    // Command codes on the input item.
    localparam logic CMD_REGISTER   = 1'b0;
    localparam logic CMD_UNREGISTER = 1'b1;

    // Status codes on the result item.
    localparam logic [1:0] STATUS_DONE      = 2'd0;
    localparam logic [1:0] STATUS_MISALIGN  = 2'd1;
    localparam logic [1:0] STATUS_NO_OBJECT = 2'd2;

    // Classified operations passed from the front end to the back end.
    localparam logic [1:0] OP_REGISTER   = 2'd0;
    localparam logic [1:0] OP_UNREGISTER = 2'd1;
    localparam logic [1:0] OP_REFUSE     = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [4:0]  size_log;
        logic [15:0] address;
    } op_item_t;

endpackage

FILE: rtl/slot_size_table_register_core.sv
// ============================================================================
// slot_size_table_register_core
// Power-of-two object size table with register and unregister commands.
// ============================================================================
// After reset the table is swept to zero, one entry per cycle, over all
// 2^(ADDR_BITS-SLOT_LOG) entries (4096 with the defaults); full stays high
// until the sweep ends. The back end then takes one item at a time: a
// register item fills its 2^(size_log-SLOT_LOG) slots, an unregister item
// looks up its entry and clears the slots of the object it finds, and a
// refused item or an unregister item that finds no object writes nothing.
// The table RAM takes one write per cycle, so the largest object (the whole
// address space) rewrites every entry, as the sweep does. Two items can wait
// in the front queue and one result in the output register.
module slot_size_table_register_core
    import sstr_pkg::*;
#(
    parameter int ADDR_BITS = 16,
    parameter int SLOT_LOG  = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  cmd_item,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    logic     busy_clear;
    logic     q_valid;
    op_item_t q_data;
    logic     q_pop;

    sstr_front #(
        .ADDR_BITS (ADDR_BITS),
        .SLOT_LOG  (SLOT_LOG)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .cmd_item (cmd_item),
        .hold     (busy_clear),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop)
    );

    sstr_back #(
        .ADDR_BITS (ADDR_BITS),
        .SLOT_LOG  (SLOT_LOG)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .busy_clear (busy_clear),
        .q_valid    (q_valid),
        .q_data     (q_data),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

endmodule

FILE: rtl/sstr_ram.sv
// ============================================================================
// sstr_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
module sstr_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

FILE: rtl/sstr_front.sv
// ============================================================================
// sstr_front
// Accepts input items, rounds the size and checks alignment, and holds the
// classified operations in a two-entry queue for the back end.
// ============================================================================
module sstr_front
    import sstr_pkg::*;
#(
    parameter int ADDR_BITS = 16,
    parameter int SLOT_LOG  = 4
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  in_item_t cmd_item,
    input  logic     hold,
    output logic     q_valid,
    output op_item_t q_data,
    input  logic     q_pop
);

    logic [16:0]          nm1;
    logic [4:0]           size_raw;
    logic [4:0]           size_clamped;
    logic [ADDR_BITS-1:0] addr_a;
    logic                 misaligned;
    logic                 too_big;
    op_item_t             classified;
    logic                 accept;

    op_item_t   mem_reg [2];
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;

    // Round the byte count up to a power of two: the bit length of n - 1.
    always_comb
    begin
        nm1      = cmd_item.num_bytes - 17'd1;
        size_raw = 5'd0;
        for (int i = 0; i < 17; i++)
        begin
            if (nm1[i])
            begin
                size_raw = 5'(i + 1);
            end
        end
        if (cmd_item.num_bytes <= 17'd1)
        begin
            size_raw = 5'd0;
        end
        size_clamped = (size_raw < 5'(SLOT_LOG)) ? 5'(SLOT_LOG) : size_raw;
        addr_a       = ADDR_BITS'(cmd_item.address);
        misaligned   = 1'b0;
        for (int i = 0; i < ADDR_BITS; i++)
        begin
            if ((6'(i) < {1'b0, size_clamped}) && addr_a[i])
            begin
                misaligned = 1'b1;
            end
        end
        too_big = {1'b0, size_clamped} > 6'(ADDR_BITS);

        classified.address  = cmd_item.address;
        classified.size_log = size_clamped;
        if (cmd_item.cmd == CMD_UNREGISTER)
        begin
            classified.op = OP_UNREGISTER;
        end
        else if (misaligned || too_big)
        begin
            classified.op = OP_REFUSE;
        end
        else
        begin
            classified.op = OP_REGISTER;
        end
    end

    assign full    = (count_reg == 2'd2) || hold;
    assign accept  = push && !full;
    assign q_valid = (count_reg != 2'd0);
    assign q_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (accept && !(q_pop && q_valid))
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!accept && q_pop && q_valid)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop && q_valid)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

FILE: rtl/sstr_back.sv
// ============================================================================
// sstr_back
// Carries out queued operations against the size table: fills or clears the
// covered slots one per cycle and holds the result for the pop side.
// ============================================================================
module sstr_back
    import sstr_pkg::*;
#(
    parameter int ADDR_BITS = 16,
    parameter int SLOT_LOG  = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    output logic      busy_clear,
    input  logic      q_valid,
    input  op_item_t  q_data,
    output logic      q_pop,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    localparam int IDX_W = (ADDR_BITS - SLOT_LOG > 0) ? (ADDR_BITS - SLOT_LOG) : 1;
    localparam int DEPTH = 1 << IDX_W;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_LOOKUP = 3'd2;
    localparam logic [2:0] ST_FILL   = 3'd3;
    localparam logic [2:0] ST_RESULT = 3'd4;

    logic [2:0]           state_reg,     state_next;
    logic [IDX_W-1:0]     cnt_reg,       cnt_next;
    logic [IDX_W-1:0]     first_reg,     first_next;
    logic [IDX_W-1:0]     last_reg,      last_next;
    logic [4:0]           fill_val_reg,  fill_val_next;
    logic [ADDR_BITS-1:0] addr_reg,      addr_next;
    out_item_t            res_reg,       res_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_reg,       out_next;

    logic                 we;
    logic [IDX_W-1:0]     waddr;
    logic [4:0]           wdata;
    logic [IDX_W-1:0]     raddr;
    logic [4:0]           rdata;

    logic [ADDR_BITS-1:0] q_addr_a;
    logic [4:0]           reg_span;
    logic [5:0]           ee;
    logic [5:0]           unreg_span;
    logic [ADDR_BITS-1:0] unreg_base;
    logic [IDX_W-1:0]     reg_last;
    logic [IDX_W-1:0]     unreg_last;
    logic                 out_free;

    sstr_ram #(
        .WIDTH (5),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign busy_clear = (state_reg == ST_CLEAR);
    assign empty      = !out_valid_reg;
    assign result     = out_reg;
    assign out_free   = !out_valid_reg || pop;
    assign q_addr_a   = ADDR_BITS'(q_data.address);
    assign raddr      = IDX_W'(q_addr_a >> SLOT_LOG);

    // Slot span masks and the aligned base of an object being removed.
    always_comb
    begin
        reg_span = q_data.size_log - 5'(SLOT_LOG);
        ee       = ({1'b0, rdata} > 6'(ADDR_BITS)) ? 6'(ADDR_BITS) : {1'b0, rdata};
        unreg_span = (ee >= 6'(SLOT_LOG)) ? (ee - 6'(SLOT_LOG)) : 6'd0;
        for (int i = 0; i < IDX_W; i++)
        begin
            reg_last[i]   = (6'(i) < {1'b0, reg_span});
            unreg_last[i] = (6'(i) < unreg_span);
        end
        for (int i = 0; i < ADDR_BITS; i++)
        begin
            unreg_base[i] = (6'(i) >= ee) ? addr_reg[i] : 1'b0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        fill_val_next  = fill_val_reg;
        addr_next      = addr_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        q_pop          = 1'b0;
        we             = 1'b0;
        waddr          = first_reg + cnt_reg;
        wdata          = fill_val_reg;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                we    = 1'b1;
                waddr = cnt_reg;
                wdata = 5'd0;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == {IDX_W{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    addr_next = q_addr_a;
                    cnt_next  = '0;
                    case (q_data.op)
                        OP_REGISTER:
                        begin
                            first_next    = IDX_W'(q_addr_a >> SLOT_LOG);
                            last_next     = reg_last;
                            fill_val_next = q_data.size_log;
                            res_next      = '{STATUS_DONE, q_data.size_log,
                                              16'(q_addr_a)};
                            state_next    = ST_FILL;
                        end
                        OP_UNREGISTER:
                        begin
                            state_next = ST_LOOKUP;
                        end
                        default:
                        begin
                            res_next   = '{STATUS_MISALIGN, 5'd0, 16'd0};
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_LOOKUP:
            begin
                if (rdata == 5'd0)
                begin
                    res_next   = '{STATUS_NO_OBJECT, 5'd0, 16'd0};
                    state_next = ST_RESULT;
                end
                else
                begin
                    first_next    = IDX_W'(unreg_base >> SLOT_LOG);
                    last_next     = unreg_last;
                    fill_val_next = 5'd0;
                    res_next      = '{STATUS_DONE, rdata, 16'(unreg_base)};
                    state_next    = ST_FILL;
                end
            end
            ST_FILL:
            begin
                we       = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == last_reg)
                begin
                    cnt_next   = '0;
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg    <= first_next;
        last_reg     <= last_next;
        fill_val_reg <= fill_val_next;
        addr_reg     <= addr_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

endmodule

FILE: verif/slot_size_table_checker.sv
// ============================================================================
// slot_size_table_checker
// Watches both queues of the slot size table core and checks its results.
// ============================================================================
// It keeps its own copy of the size table. Each accepted command is applied
// to that copy, and the result it should produce is queued. Each popped
// result is compared field by field with the oldest queued result.
module slot_size_table_checker
    import sstr_pkg::*;
#(
    parameter int ADDR_BITS = 16,
    parameter int SLOT_LOG  = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  in_item_t    cmd_item,
    input  logic        empty,
    input  logic        pop,
    input  out_item_t   result,
    output int unsigned fail_count,
    output int unsigned pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TABLE_DEPTH = 1 << (ADDR_BITS - SLOT_LOG);
    localparam logic [31:0] ADDR_MASK   = (ADDR_BITS >= 32) ? '1 : (32'd1 << ADDR_BITS) - 1;

    logic [4:0]  slot_log_table [TABLE_DEPTH];
    out_item_t   expected_results [$];
    out_item_t   oldest;
    int unsigned mismatch_total = 0;

    initial begin
        fail_count    = 0;
        pending_count = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_total++;
    endtask

    // Writes one value into a run of slots, wrapping at the end of the table.
    function automatic void write_run(input logic [31:0] first, input int unsigned count,
                                      input logic [4:0] value);
        for (int unsigned i = 0; i < count; i++) begin
            slot_log_table[(first + i) & (TABLE_DEPTH - 1)] = value;
        end
    endfunction

    // Applies one command to the table copy and returns the result it causes.
    function automatic out_item_t apply_command(input in_item_t item);
        out_item_t   r;
        logic [31:0] addr;
        logic [31:0] base;
        int unsigned lg;
        int unsigned entry;
        int unsigned count;
        r    = '0;
        addr = 32'(item.address) & ADDR_MASK;
        if (item.cmd == CMD_REGISTER) begin
            lg = 0;
            while (lg < 40 && (64'd1 << lg) < 64'(item.num_bytes)) begin
                lg++;
            end
            if (lg < SLOT_LOG) begin
                lg = SLOT_LOG;
            end
            if (lg > ADDR_BITS || (64'(addr) & ((64'd1 << lg) - 1)) != 0) begin
                r.status = STATUS_MISALIGN;
            end else begin
                write_run(addr >> SLOT_LOG, 1 << (lg - SLOT_LOG), 5'(lg));
                r.status      = STATUS_DONE;
                r.size_log    = 5'(lg);
                r.object_base = 16'(addr);
            end
        end else begin
            entry = slot_log_table[(addr >> SLOT_LOG) & (TABLE_DEPTH - 1)];
            if (entry == 0) begin
                r.status = STATUS_NO_OBJECT;
            end else begin
                r.size_log = 5'(entry);
                // Entries wider than the address space clear the whole table.
                if (entry > ADDR_BITS) begin
                    entry = ADDR_BITS;
                end
                count = (entry >= SLOT_LOG) ? (1 << (entry - SLOT_LOG)) : 1;
                base  = 32'(64'(addr) & ~((64'd1 << entry) - 1)) & ADDR_MASK;
                write_run(base >> SLOT_LOG, count, 5'd0);
                r.status      = STATUS_DONE;
                r.object_base = 16'(base);
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            expected_results.delete();
            foreach (slot_log_table[i]) begin
                slot_log_table[i] = '0;
            end
            pending_count <= 0;
        end else begin
            // A result can never belong to the item accepted at the same edge,
            // so the pop side is handled first.
            if (pop && !empty) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result with no item waiting: status %0d log %0d base %h",
                                              result.status, result.size_log, result.object_base));
                end else begin
                    oldest = expected_results.pop_front();
                    if (result.status !== oldest.status) begin
                        report_mismatch($sformatf("status %0d, predicted %0d",
                                                  result.status, oldest.status));
                    end
                    if (result.size_log !== oldest.size_log) begin
                        report_mismatch($sformatf("size_log %0d, predicted %0d",
                                                  result.size_log, oldest.size_log));
                    end
                    if (result.object_base !== oldest.object_base) begin
                        report_mismatch($sformatf("object_base %h, predicted %h",
                                                  result.object_base, oldest.object_base));
                    end
                end
            end
            if (push && !full) begin
                expected_results.push_back(apply_command(cmd_item));
            end
            pending_count <= expected_results.size();
        end
        fail_count <= mismatch_total;
    end

endmodule

FILE: verif/tb_slot_size_table_register_core.sv
// ============================================================================
// tb_slot_size_table_register_core
// Stimulus and verdict for the slot size table register core.
// ============================================================================
// A directed run covers free slots, tiny and zero lengths, misaligned and
// oversized registers, overlaps and whole-space objects. Random items follow
// in four phases of sender idling and receiver stalling. Most random items either
// register aligned objects or later unregister them from an inner address.
module tb_slot_size_table_register_core
    import sstr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          ADDR_BITS        = 16;
    localparam int          SLOT_LOG         = 4;
    localparam time         CLK_PERIOD       = 10ns;
    localparam int unsigned ITEMS_PER_PHASE  = 29;
    localparam int unsigned WATCHDOG_LIMIT   = 20000;
    localparam int unsigned END_DRAIN_CYCLES = 4200;

    typedef struct {
        logic [15:0] base;
        int unsigned lg;
    } live_object_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        push;
    logic        full;
    in_item_t    cmd_item;
    logic        empty;
    logic        pop;
    out_item_t   result;
    int unsigned fail_count;
    int unsigned pending_count;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned quiet_cycles   = 0;

    live_object_t live_objects [$];

    always #(CLK_PERIOD / 2) clk = ~clk;

    slot_size_table_register_core #(
        .ADDR_BITS (ADDR_BITS),
        .SLOT_LOG  (SLOT_LOG)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .cmd_item (cmd_item),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

    slot_size_table_checker #(
        .ADDR_BITS (ADDR_BITS),
        .SLOT_LOG  (SLOT_LOG)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .cmd_item      (cmd_item),
        .empty         (empty),
        .pop           (pop),
        .result        (result),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always @(posedge clk) begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Ends the run when neither side has moved an item for too long.
    always @(posedge clk) begin
        if (!rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_item(input logic cmd, input logic [15:0] address,
                             input logic [16:0] num_bytes);
        in_item_t item;
        item.cmd       = cmd;
        item.address   = address;
        item.num_bytes = num_bytes;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push     <= 1'b1;
        cmd_item <= item;
        @(posedge clk);
        while (full) begin
            @(posedge clk);
        end
    endtask

    // Mostly small objects; the largest ones fill the whole table.
    function automatic int unsigned pick_log();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 75) begin
            return $urandom_range(8, SLOT_LOG);
        end else if (roll < 96) begin
            return $urandom_range(12, 9);
        end
        return $urandom_range(ADDR_BITS, 13);
    endfunction

    // A length that rounds up to exactly 2^lg bytes, or that fits one slot for lg <= SLOT_LOG.
    function automatic logic [16:0] length_for_log(input int unsigned lg);
        if (lg <= SLOT_LOG) begin
            return 17'($urandom_range(1 << SLOT_LOG, 0));
        end
        return 17'($urandom_range(1 << lg, (1 << (lg - 1)) + 1));
    endfunction

    function automatic logic [15:0] aligned_address(input int unsigned lg);
        return 16'($urandom) & ~16'((32'd1 << lg) - 1);
    endfunction

    task automatic send_directed();
        send_item(CMD_UNREGISTER, 16'h0000, 17'h00000);
        send_item(CMD_REGISTER,   16'h0000, 17'd0);
        send_item(CMD_REGISTER,   16'h0010, 17'd1);
        send_item(CMD_REGISTER,   16'h0020, 17'd16);
        send_item(CMD_REGISTER,   16'h0040, 17'd17);
        send_item(CMD_REGISTER,   16'h0008, 17'd4);
        send_item(CMD_REGISTER,   16'h0030, 17'd32);
        send_item(CMD_REGISTER,   16'h0000, 17'd65537);
        send_item(CMD_REGISTER,   16'hFFFF, 17'h1FFFF);
        send_item(CMD_UNREGISTER, 16'h0045, 17'h1FFFF);
        send_item(CMD_UNREGISTER, 16'h0045, 17'h00000);
        send_item(CMD_UNREGISTER, 16'h0010, 17'h00000);
        send_item(CMD_REGISTER,   16'hFFF0, 17'd16);
        send_item(CMD_UNREGISTER, 16'hFFFF, 17'h00000);
        send_item(CMD_REGISTER,   16'h8000, 17'd32768);
        send_item(CMD_REGISTER,   16'h8100, 17'd256);
        send_item(CMD_UNREGISTER, 16'h8000, 17'h00000);
        send_item(CMD_UNREGISTER, 16'h8100, 17'h00000);
        send_item(CMD_REGISTER,   16'h0000, 17'd65536);
        send_item(CMD_UNREGISTER, 16'h1234, 17'h00000);
        send_item(CMD_UNREGISTER, 16'h0000, 17'h00000);
        send_item(CMD_REGISTER,   16'h0000, 17'd65535);
        send_item(CMD_UNREGISTER, 16'hFFFF, 17'h00000);
    endtask

    task automatic send_random(input int unsigned count);
        int unsigned  roll;
        int unsigned  lg;
        int unsigned  idx;
        live_object_t obj;
        for (int unsigned k = 0; k < count; k++) begin
            roll = $urandom_range(99);
            lg   = pick_log();
            if (roll < 35 && live_objects.size() > 0) begin
                idx = $urandom_range(live_objects.size() - 1, 0);
                obj = live_objects[idx];
                live_objects.delete(idx);
                send_item(CMD_UNREGISTER,
                          obj.base + 16'($urandom_range((1 << obj.lg) - 1, 0)),
                          17'($urandom));
            end else if (roll < 80) begin
                obj.base = aligned_address(lg);
                obj.lg   = lg;
                live_objects.push_back(obj);
                send_item(CMD_REGISTER, obj.base, length_for_log(lg));
            end else if (roll < 88) begin
                send_item(CMD_REGISTER,
                          aligned_address(lg) | 16'($urandom_range((1 << lg) - 1, 1)),
                          length_for_log(lg));
            end else if (roll < 93) begin
                send_item(CMD_REGISTER, 16'($urandom),
                          17'($urandom_range(17'h1FFFF, 65537)));
            end else begin
                send_item(CMD_UNREGISTER, 16'($urandom), 17'($urandom));
            end
        end
    endtask

    initial begin
        rst_n    = 1'b0;
        push     = 1'b0;
        pop      = 1'b0;
        cmd_item = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        send_directed();

        send_random(ITEMS_PER_PHASE);
        send_idle_pct = 63;
        send_random(ITEMS_PER_PHASE);
        send_idle_pct  = 0;
        recv_stall_pct = 63;
        send_random(ITEMS_PER_PHASE);
        send_idle_pct  = 23;
        recv_stall_pct = 23;
        send_random(ITEMS_PER_PHASE);
        push <= 1'b0;

        // Wait for the checker's registered count to take in the last accepted item.
        @(posedge clk);
        while (pending_count != 0) begin
            @(posedge clk);
        end
        // Any stray result from a long table sweep shows up within this window.
        repeat (END_DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/sstr_pkg.sv
rtl/sstr_ram.sv
rtl/sstr_front.sv
rtl/sstr_back.sv
rtl/slot_size_table_register_core.sv
verif/slot_size_table_checker.sv
verif/tb_slot_size_table_register_core.sv
